// ===== sv/tca_pkg.sv =====
// Shared types, constants and saturation helper for the trigger condition ALU.
package tca_pkg;

  // Q16.16 number format and timing constants.
  localparam int unsigned QW        = 32;
  localparam int unsigned FRAC      = 16;
  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned TPROD_W   = 41;
  localparam int unsigned MS_W      = TPROD_W - FRAC;
  localparam int unsigned TOL_W     = 16;

  localparam logic [TOL_W-1:0] TOL_RESET  = 16'd65;
  localparam logic [QW-1:0]    NEVER_TIME = '1;
  localparam logic [QW-1:0]    Q_MAX      = 32'h7FFF_FFFF;
  localparam logic [QW-1:0]    Q_MIN      = 32'h8000_0000;

  // Operator codes as they arrive on the input stream.
  typedef enum logic [3:0] {
    OP_AND   = 4'd0,
    OP_OR    = 4'd1,
    OP_LE    = 4'd2,
    OP_GE    = 4'd3,
    OP_LT    = 4'd4,
    OP_GT    = 4'd5,
    OP_EQ    = 4'd6,
    OP_AFTER = 4'd7,
    OP_FOR   = 4'd8,
    OP_ADD   = 4'd9,
    OP_SUB   = 4'd10,
    OP_MUL   = 4'd11,
    OP_DIV   = 4'd12,
    OP_NOP   = 4'd15
  } op_e;

  // One classified word as it waits in the queue.
  typedef struct packed {
    op_e                  op;
    logic signed [QW-1:0] num_a;
    logic signed [QW-1:0] num_b;
    logic                 bool_a;
    logic                 bool_b;
    logic [QW-1:0]        since_time;
    logic [QW-1:0]        now_ms;
    logic [QW-1:0]        mag_a;
    logic [QW-1:0]        mag_b;
    logic                 neg;
  } item_t;

  // One result word.
  typedef struct packed {
    logic                 bool_result;
    logic signed [QW-1:0] num_result;
    logic                 result_is_number;
    logic                 overflow;
  } result_t;

  typedef struct packed {
    logic [QW-1:0] val;
    logic          ovf;
  } sat_t;

  // Applies a sign to a magnitude and clamps it to the 32-bit range.
  function automatic sat_t sat_mag(logic [47:0] mag, logic neg);
    sat_t r;
    r.ovf = 1'b0;
    if (neg) begin
      if (mag > 48'h0000_8000_0000) begin
        r.val = Q_MIN;
        r.ovf = 1'b1;
      end else begin
        r.val = QW'(~mag[QW-1:0] + 32'd1);
      end
    end else begin
      if (mag > 48'h0000_7FFF_FFFF) begin
        r.val = Q_MAX;
        r.ovf = 1'b1;
      end else begin
        r.val = mag[QW-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/tca_front.sv =====
// Front end: unpacks an input word, decodes the operator and forms magnitudes.
module tca_front (
  input  logic [3:0]                   mode_i,
  input  logic [tca_pkg::QW-1:0]       num_a_i,
  input  logic [tca_pkg::QW-1:0]       num_b_i,
  input  logic                         bool_a_i,
  input  logic                         bool_b_i,
  input  logic [tca_pkg::QW-1:0]       since_time_i,
  input  logic [tca_pkg::QW-1:0]       now_ms_i,
  output tca_pkg::item_t               item_o
);
  import tca_pkg::*;

  op_e op;

  // Undefined operator codes become a no-op that answers with zeros.
  always_comb begin
    case (op_e'(mode_i))
      OP_AND:   op = OP_AND;
      OP_OR:    op = OP_OR;
      OP_LE:    op = OP_LE;
      OP_GE:    op = OP_GE;
      OP_LT:    op = OP_LT;
      OP_GT:    op = OP_GT;
      OP_EQ:    op = OP_EQ;
      OP_AFTER: op = OP_AFTER;
      OP_FOR:   op = OP_FOR;
      OP_ADD:   op = OP_ADD;
      OP_SUB:   op = OP_SUB;
      OP_MUL:   op = OP_MUL;
      OP_DIV:   op = OP_DIV;
      default:  op = OP_NOP;
    endcase
  end

  // Operand magnitudes and result sign for multiply and divide.
  always_comb begin
    item_o.op         = op;
    item_o.num_a      = num_a_i;
    item_o.num_b      = num_b_i;
    item_o.bool_a     = bool_a_i;
    item_o.bool_b     = bool_b_i;
    item_o.since_time = since_time_i;
    item_o.now_ms     = now_ms_i;
    item_o.mag_a      = num_a_i[QW-1] ? QW'(~num_a_i + 32'd1) : num_a_i;
    item_o.mag_b      = num_b_i[QW-1] ? QW'(~num_b_i + 32'd1) : num_b_i;
    item_o.neg        = num_a_i[QW-1] ^ num_b_i[QW-1];
  end

endmodule

// ===== sv/tca_queue.sv =====
// Two-entry queue that decouples the front end from the execution pipeline.
module tca_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tca_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tca_pkg::item_t out_item_o
);
  import tca_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q;
  logic        push;
  logic        pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== sv/tca_back.sv =====
// Back end: execution pipeline with a multiplier, timing compare and a divider.
module tca_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      eq_tolerance_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tca_pkg::item_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tca_pkg::result_t out_result_o
);
  import tca_pkg::*;

  // Word state carried through the divider stages.
  typedef struct packed {
    op_e           op;
    result_t       res;
    logic [QW-1:0] rem;
    logic [QW-1:0] nlo;
    logic [QW-1:0] divisor;
    logic [QW-1:0] quo;
    logic          pre_ovf;
    logic          b_zero;
    logic          a_neg;
    logic          a_zero;
    logic          neg;
  } pipe_t;

  // Extra first-stage state for multiply and timing.
  typedef struct packed {
    logic            bool_a;
    logic [63:0]     prod;
    logic [TPROD_W-1:0] tprod;
    logic            tpos;
    logic [QW-1:0]   elapsed;
    logic            never;
  } side_t;

  logic                 en;
  logic                 p1_vld_q, p2_vld_q, out_vld_q;
  logic [DIV_STEPS-1:0] dv_vld_q;
  pipe_t                p1_d, p1_q, p2_d, p2_q;
  side_t                s1_d, s1_q;
  pipe_t                dv_q [DIV_STEPS];
  result_t              fin_d, out_q;

  // The whole pipeline moves whenever the output register can take a word.
  assign en           = !out_vld_q || out_ready_i;
  assign in_ready_o   = en;
  assign out_valid_o  = out_vld_q;
  assign out_result_o = out_q;

  // One restoring division step.
  function automatic pipe_t div_step(pipe_t s);
    pipe_t      r;
    logic [32:0] t;
    r = s;
    t = {s.rem, s.nlo[QW-1]};
    if (t >= {1'b0, s.divisor}) begin
      r.rem = QW'(t - {1'b0, s.divisor});
      r.quo = {s.quo[QW-2:0], 1'b1};
    end else begin
      r.rem = t[QW-1:0];
      r.quo = {s.quo[QW-2:0], 1'b0};
    end
    r.nlo = {s.nlo[QW-2:0], 1'b0};
    return r;
  endfunction

  // Stage one: compares, add and subtract, products and divider setup.
  always_comb begin
    logic signed [32:0] diff;
    logic signed [32:0] sum;
    logic [32:0]        dmag;
    logic [QW-1:0]      sec;
    diff = 33'(in_item_i.num_a) - 33'(in_item_i.num_b);
    sum  = 33'(in_item_i.num_a) + 33'(in_item_i.num_b);
    dmag = diff[32] ? 33'(-diff) : diff;
    sec  = (in_item_i.op == OP_FOR) ? in_item_i.num_b : in_item_i.num_a;

    p1_d         = '0;
    p1_d.op      = in_item_i.op;
    p1_d.rem     = {16'd0, in_item_i.mag_a[QW-1:FRAC]};
    p1_d.nlo     = {in_item_i.mag_a[FRAC-1:0], 16'd0};
    p1_d.divisor = in_item_i.mag_b;
    p1_d.pre_ovf = ({16'd0, in_item_i.mag_a[QW-1:FRAC]} >= in_item_i.mag_b);
    p1_d.b_zero  = (in_item_i.mag_b == '0);
    p1_d.a_neg   = in_item_i.num_a[QW-1];
    p1_d.a_zero  = (in_item_i.num_a == '0);
    p1_d.neg     = in_item_i.neg;

    case (in_item_i.op)
      OP_AND: p1_d.res.bool_result = in_item_i.bool_a && in_item_i.bool_b;
      OP_OR:  p1_d.res.bool_result = in_item_i.bool_a || in_item_i.bool_b;
      OP_LE:  p1_d.res.bool_result = in_item_i.num_a <= in_item_i.num_b;
      OP_GE:  p1_d.res.bool_result = in_item_i.num_a >= in_item_i.num_b;
      OP_LT:  p1_d.res.bool_result = in_item_i.num_a < in_item_i.num_b;
      OP_GT:  p1_d.res.bool_result = in_item_i.num_a > in_item_i.num_b;
      OP_EQ:  p1_d.res.bool_result = dmag <= {17'd0, eq_tolerance_i};
      OP_ADD, OP_SUB: begin
        p1_d.res.result_is_number = 1'b1;
        if (in_item_i.op == OP_SUB) sum = diff;
        if (sum[32] != sum[31]) begin
          p1_d.res.overflow   = 1'b1;
          p1_d.res.num_result = sum[32] ? Q_MIN : Q_MAX;
        end else begin
          p1_d.res.num_result = sum[QW-1:0];
        end
      end
      OP_MUL, OP_DIV: p1_d.res.result_is_number = 1'b1;
      default: ;
    endcase

    s1_d.bool_a  = in_item_i.bool_a;
    s1_d.prod    = 64'(in_item_i.mag_a) * 64'(in_item_i.mag_b);
    s1_d.tpos    = !sec[QW-1] && (sec != '0);
    s1_d.tprod   = TPROD_W'(sec[QW-2:0]) * TPROD_W'(MS_PER_S);
    s1_d.elapsed = in_item_i.now_ms - in_item_i.since_time;
    s1_d.never   = (in_item_i.since_time == NEVER_TIME);
  end

  // Stage two: multiply saturation and the elapsed-time tests.
  always_comb begin
    sat_t            ms;
    logic [MS_W-1:0] lim;
    logic            late;
    ms   = sat_mag(s1_q.prod[63:FRAC], p1_q.neg);
    lim  = s1_q.tpos ? s1_q.tprod[TPROD_W-1:FRAC] : '0;
    late = !s1_q.never && (s1_q.elapsed > QW'(lim));
    p2_d = p1_q;
    case (p1_q.op)
      OP_MUL: begin
        p2_d.res.num_result = ms.val;
        p2_d.res.overflow   = ms.ovf;
      end
      OP_AFTER: p2_d.res.bool_result = late;
      OP_FOR:   p2_d.res.bool_result = late && s1_q.bool_a;
      default: ;
    endcase
  end

  // Front stages of the pipeline.
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      s1_q <= s1_d;
      p2_q <= p2_d;
    end
  end

  // Divider stages, one quotient bit each.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    pipe_t st_in;
    if (k == 0) begin : g_first
      assign st_in = p2_q;
    end else begin : g_next
      assign st_in = dv_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) dv_q[k] <= div_step(st_in);
    end
  end

  // Final stage: divide-by-zero, early overflow and quotient saturation.
  always_comb begin
    pipe_t l;
    sat_t  qs;
    l     = dv_q[DIV_STEPS-1];
    qs    = sat_mag({16'd0, l.quo}, l.neg);
    fin_d = l.res;
    if (l.op == OP_DIV) begin
      fin_d.overflow = 1'b1;
      if (l.b_zero) begin
        fin_d.num_result = l.a_neg ? Q_MIN : (l.a_zero ? '0 : Q_MAX);
      end else if (l.pre_ovf) begin
        fin_d.num_result = l.neg ? Q_MIN : Q_MAX;
      end else begin
        fin_d.num_result = qs.val;
        fin_d.overflow   = qs.ovf;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en) out_q <= fin_d;
  end

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q  <= in_valid_i;
      p2_vld_q  <= p1_vld_q;
      dv_vld_q  <= {dv_vld_q[DIV_STEPS-2:0], p2_vld_q};
      out_vld_q <= dv_vld_q[DIV_STEPS-1];
    end
  end

endmodule

// ===== sv/trigger_condition_alu.sv =====
// Top level of the trigger condition ALU: stream ports, tolerance register, assertions.
//
// Evaluates one operator of a trigger expression per word on Q16.16 operands
// and returns exactly one result word per input word, in order. A new word can
// be taken every cycle while the result stream is not held back; each word
// passes through the queue, two operand stages, the 32-stage pipelined
// restoring divider (one quotient bit per stage) and the output register. All
// operators share that pipeline, so results never reorder. The tolerance
// register resets to 65 and may be written at any time the block holds no word
// in flight.
module trigger_condition_alu (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // num_a[31:0], num_b[63:32], bool_a[64], bool_b[65], since_time[97:66],
  // now_ms[129:98], zero fill [135:130]
  input  logic [135:0]  s_axis_tdata,
  // mode[3:0]
  input  logic [3:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // bool_result[0], num_result[32:1], overflow[33], zero fill [39:34]
  output logic [39:0]   m_axis_tdata,
  // result_is_number[0]
  output logic          m_axis_tuser,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i
);
  import tca_pkg::*;

  logic [TOL_W-1:0] tol_q;
  item_t            fr_item;
  item_t            q_item;
  logic             q_valid;
  logic             q_ready;
  result_t          res;

  // Equality tolerance register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  tca_front u_front (
    .mode_i       (s_axis_tuser),
    .num_a_i      (s_axis_tdata[31:0]),
    .num_b_i      (s_axis_tdata[63:32]),
    .bool_a_i     (s_axis_tdata[64]),
    .bool_b_i     (s_axis_tdata[65]),
    .since_time_i (s_axis_tdata[97:66]),
    .now_ms_i     (s_axis_tdata[129:98]),
    .item_o       (fr_item)
  );

  tca_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (fr_item),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_item_o  (q_item)
  );

  tca_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .eq_tolerance_i (tol_q),
    .in_valid_i     (q_valid),
    .in_ready_o     (q_ready),
    .in_item_i      (q_item),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_result_o   (res)
  );

  // Result word packing.
  assign m_axis_tdata = {6'd0, res.overflow, res.num_result, res.bool_result};
  assign m_axis_tuser = res.result_is_number;

  // A numeric result never carries a true boolean.
  a_num_no_bool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[0])
    else $error("numeric result with boolean set");

  // A boolean result carries a zero number and no overflow.
  a_bool_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[33:1] == 33'd0))
    else $error("boolean result with numeric fields set");

  // An overflow always comes with a saturated bound or a zero result.
  a_ovf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33] |->
      (m_axis_tdata[32:1] == Q_MAX) || (m_axis_tdata[32:1] == Q_MIN) ||
      (m_axis_tdata[32:1] == 32'd0))
    else $error("overflow without a saturated result");

endmodule
